>>> rtl/core/bsr_pkg.sv
// Package for the sensor baseline removal filter: field widths, register codes,
// sequencer states and the control structs shared by the core modules.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package bsr_pkg;

  // Field widths of the words on the channels.
  localparam int CH_W       = 7;
  localparam int SAMPLE_W   = 12;
  localparam int OUT_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Register widths.
  localparam int WIN_W  = 5;
  localparam int GAIN_W = 8;
  localparam int MASK_W = 64;

  // Datapath widths.
  localparam int SCALE_SH = 8;       // samples are scaled by 256
  localparam int S_W      = 16;      // corrected sample before clamping
  localparam int T_W      = S_W + SCALE_SH;
  localparam int ACC_W    = 25;
  localparam int RING_W   = 20;
  localparam int DIV_W    = 24;      // magnitude of a non-negative accumulator
  localparam int RES_W    = 18;
  localparam int PROD_W   = 27;
  localparam int WIN_LIMIT = 31;     // largest value the window register holds

  localparam logic [RING_W-1:0] RING_MAX = '1;
  localparam logic [OUT_W-1:0]  OUT_MAX  = '1;

  // Parameter defaults.
  localparam int CHANNELS_DEF   = 128;
  localparam int MAX_WINDOW_DEF = 16;
  localparam int FULL_SCALE_DEF = 4095;

  // Register reset values.
  localparam logic [WIN_W-1:0]  WIN_RST  = 5'd8;
  localparam logic [GAIN_W-1:0] GAIN_RST = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 3'd0,
    CFG_GAIN   = 3'd1,
    CFG_INV_LO = 3'd2,
    CFG_INV_HI = 3'd3
  } bsr_cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED,
    S_READ,
    S_SUM,
    S_DIV,
    S_SAT,
    S_RES,
    S_MUL,
    S_FINISH
  } bsr_state_t;

  // Effective settings handed from the register bank to the sequencer.
  typedef struct packed {
    logic [WIN_W-1:0]  win;
    logic [GAIN_W-1:0] gain;
  } bsr_cfg_t;

  // Strobes from the sequencer to the channel state memories.
  typedef struct packed {
    logic rd;
    logic acc_we;
    logic ring_we;
  } bsr_mem_ctl_t;

endpackage

>>> rtl/core/bsr_in_if.sv
// Input channel of the baseline removal filter: one sample word per handshake.
// Depends on bsr_pkg for the field widths.
`timescale 1ns / 1ps

interface bsr_in_if;
  logic                           valid;
  logic                           ready;
  logic [bsr_pkg::CH_W-1:0]       channel;
  logic [bsr_pkg::SAMPLE_W-1:0]   sample;
  logic                           first_record;

  modport source (output valid, channel, sample, first_record, input ready);
  modport sink   (input valid, channel, sample, first_record, output ready);
endinterface

>>> rtl/core/bsr_out_if.sv
// Result channel of the baseline removal filter: one result word per handshake.
// Depends on bsr_pkg for the field widths.
`timescale 1ns / 1ps

interface bsr_out_if;
  logic                        valid;
  logic                        ready;
  logic [bsr_pkg::OUT_W-1:0]   filtered;
  logic [bsr_pkg::OUT_W-1:0]   raw_corrected;

  modport source (output valid, filtered, raw_corrected, input ready);
  modport sink   (input valid, filtered, raw_corrected, output ready);
endinterface

>>> rtl/core/bsr_cfg_if.sv
// Configuration write channel of the baseline removal filter.
// Depends on bsr_pkg for the index and data widths.
`timescale 1ns / 1ps

interface bsr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bsr_pkg::CFG_IDX_W-1:0]    index;
  logic [bsr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/bsr_cfg_regs.sv
// Configuration register bank: window, gain and the per-channel inversion mask.
// Depends on bsr_pkg and bsr_cfg_if.
`timescale 1ns / 1ps

module bsr_cfg_regs #(
  parameter int MAX_WINDOW = bsr_pkg::MAX_WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  bsr_cfg_if.sink                   cfg_ch,
  input  logic [bsr_pkg::CH_W-1:0]  channel,
  output bsr_pkg::bsr_cfg_t         eff,
  output logic                      invert
);

  localparam int LMAX = (MAX_WINDOW < bsr_pkg::WIN_LIMIT) ? MAX_WINDOW : bsr_pkg::WIN_LIMIT;

  logic [bsr_pkg::WIN_W-1:0]    win_r;
  logic [bsr_pkg::GAIN_W-1:0]   gain_r;
  logic [bsr_pkg::MASK_W-1:0]   inv_lo_r;
  logic [bsr_pkg::MASK_W-1:0]   inv_hi_r;
  logic [2*bsr_pkg::MASK_W-1:0] mask;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= bsr_pkg::WIN_RST;
      gain_r   <= bsr_pkg::GAIN_RST;
      inv_lo_r <= '0;
      inv_hi_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (bsr_pkg::bsr_cfg_idx_t'(cfg_ch.index))
        bsr_pkg::CFG_WINDOW: win_r    <= cfg_ch.data[bsr_pkg::WIN_W-1:0];
        bsr_pkg::CFG_GAIN:   gain_r   <= cfg_ch.data[bsr_pkg::GAIN_W-1:0];
        bsr_pkg::CFG_INV_LO: inv_lo_r <= cfg_ch.data;
        bsr_pkg::CFG_INV_HI: inv_hi_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // A window of zero acts as one; a window above the ring depth is clipped.
  always_comb begin
    if (win_r == '0) begin
      eff.win = bsr_pkg::WIN_W'(1);
    end else if (win_r > bsr_pkg::WIN_W'(LMAX)) begin
      eff.win = bsr_pkg::WIN_W'(LMAX);
    end else begin
      eff.win = win_r;
    end
    eff.gain = (gain_r == '0) ? bsr_pkg::GAIN_W'(1) : gain_r;
  end

  assign mask   = {inv_hi_r, inv_lo_r};
  assign invert = mask[channel];

endmodule

>>> rtl/core/bsr_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle over the accumulator.
// Depends on bsr_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps

module bsr_serial_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bsr_pkg::DIV_W-1:0]   dividend,
  input  logic [bsr_pkg::WIN_W-1:0]   divisor,
  output logic                        done,
  output logic [bsr_pkg::DIV_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(bsr_pkg::DIV_W);

  logic [bsr_pkg::DIV_W-1:0] quo_r;
  logic [bsr_pkg::WIN_W-1:0] rem_r, rem_nxt;
  logic [bsr_pkg::WIN_W-1:0] dvs_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r, done_r;
  logic [bsr_pkg::WIN_W:0]   trial;
  logic                      fits;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign trial   = {rem_r, quo_r[bsr_pkg::DIV_W-1]};
  assign fits    = trial >= {1'b0, dvs_r};
  assign rem_nxt = fits ? bsr_pkg::WIN_W'(trial - {1'b0, dvs_r})
                        : trial[bsr_pkg::WIN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(bsr_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[bsr_pkg::DIV_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/bsr_chan_mem.sv
// Per-channel state memories: the accumulators and the rings of baseline averages.
// Depends on bsr_pkg for the entry widths and the strobe struct.
`timescale 1ns / 1ps

module bsr_chan_mem #(
  parameter  int CHANNELS = bsr_pkg::CHANNELS_DEF,
  parameter  int ROWS     = bsr_pkg::MAX_WINDOW_DEF,
  localparam int CIW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int PW       = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                          clk,
  input  bsr_pkg::bsr_mem_ctl_t         ctl,
  input  logic [CIW-1:0]                ch,
  input  logic [PW-1:0]                 row,
  input  logic [bsr_pkg::ACC_W-1:0]     acc_wdata,
  input  logic [bsr_pkg::RING_W-1:0]    ring_wdata,
  output logic [bsr_pkg::ACC_W-1:0]     acc_rdata,
  output logic [bsr_pkg::RING_W-1:0]    ring_rdata
);

  localparam int RING_DEPTH = ROWS * CHANNELS;
  localparam int RAW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic [bsr_pkg::ACC_W-1:0]  acc_mem  [CHANNELS];
  logic [bsr_pkg::RING_W-1:0] ring_mem [RING_DEPTH];
  logic [RAW-1:0]             ring_addr;

  // Row-major layout: each ring row holds one entry for every channel.
  assign ring_addr = RAW'(RAW'(row) * RAW'(CHANNELS) + RAW'(ch));

  always_ff @(posedge clk) begin
    if (ctl.acc_we) begin
      acc_mem[ch] <= acc_wdata;
    end
    if (ctl.rd) begin
      acc_rdata <= acc_mem[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ring_we) begin
      ring_mem[ring_addr] <= ring_wdata;
    end
    if (ctl.rd) begin
      ring_rdata <= ring_mem[ring_addr];
    end
  end

endmodule

>>> rtl/core/sensor_baseline_removal_filter.sv
// Sensor baseline removal filter: per-channel moving-average baseline subtraction.
// A new input word is taken only once the word before it has left the sequencer, so words
// are handled one at a time; a first-record word first sweeps its ring rows to seed them.
// The 24-step bit-serial divider takes most of each word's time; the seed sweep adds to it.
// rst_n is synchronous, active low; it resets the configuration registers, ring position and control.
// The state memories hold no reset value; each channel is seeded by its first record.
`timescale 1ns / 1ps

module sensor_baseline_removal_filter #(
  parameter int CHANNELS   = bsr_pkg::CHANNELS_DEF,
  parameter int MAX_WINDOW = bsr_pkg::MAX_WINDOW_DEF,
  parameter int FULL_SCALE = bsr_pkg::FULL_SCALE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bsr_in_if.sink     in_ch,
  bsr_out_if.source  out_ch,
  bsr_cfg_if.sink    cfg_ch
);

  // The ring never needs more rows than the window register can select.
  localparam int LMAX = (MAX_WINDOW < bsr_pkg::WIN_LIMIT) ? MAX_WINDOW : bsr_pkg::WIN_LIMIT;
  localparam int PW   = (LMAX > 1) ? $clog2(LMAX) : 1;
  localparam int CIW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HALF = FULL_SCALE / 2;

  localparam int WW = bsr_pkg::WIN_W;
  localparam int SW = bsr_pkg::S_W;
  localparam int AW = bsr_pkg::ACC_W;
  localparam int RW = bsr_pkg::RING_W;
  localparam int TW = bsr_pkg::T_W;
  localparam int DW = bsr_pkg::DIV_W;
  localparam int VW = bsr_pkg::PROD_W + 1;

  bsr_pkg::bsr_state_t   state_r, state_nxt;
  bsr_pkg::bsr_cfg_t     eff;
  bsr_pkg::bsr_mem_ctl_t mem_ctl;

  // Control registers.
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] seed_cnt_r;
  logic          out_valid_r;

  // Working registers of the word in flight.
  logic [bsr_pkg::CH_W-1:0]     ch_r;
  logic [bsr_pkg::SAMPLE_W-1:0] raw_r;
  logic                         first_r;
  logic [SW-1:0]                s_r;
  logic [bsr_pkg::OUT_W-1:0]    rc_r;
  logic [AW-1:0]                seed_acc_r;
  logic [AW-1:0]                acc_r;
  logic [RW-1:0]                avg_r;
  logic signed [bsr_pkg::RES_W-1:0]  res_r;
  logic signed [bsr_pkg::PROD_W-1:0] prod_r;
  logic [bsr_pkg::OUT_W-1:0]    filt_out_r;
  logic [bsr_pkg::OUT_W-1:0]    rc_out_r;

  // Sequencer strobes.
  logic in_acc, div_start, seed_last, out_load;
  logic do_sum, do_sat, do_res, do_mul;

  // Datapath wires.
  logic          invert, in_range;
  logic [WW-1:0] pos_w, pos_step, pos_clamp;
  logic [SW:0]   s_diff;
  logic [SW-1:0] s_in;
  logic [RW-1:0] raw_sh_in, raw_sh;
  logic [TW-1:0] t;
  logic [AW-1:0] acc_old, acc_sum, acc_upd;
  logic [RW-1:0] ring_old, avg;
  logic [DW-1:0] quotient;
  logic          div_done;
  logic signed [RW+5:0] diff, diff_adj;
  logic signed [VW-1:0] v;
  logic [SW-1:0] v_fs;
  logic [bsr_pkg::OUT_W-1:0] filt;
  logic [CIW-1:0] ch_idx;
  logic [PW-1:0]  mem_row;
  logic [AW-1:0]  mem_acc_rdata;
  logic [RW-1:0]  mem_ring_rdata;

  bsr_cfg_regs #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .channel (in_ch.channel),
    .eff     (eff),
    .invert  (invert)
  );

  // ---------------------------------------------------------------------------
  // Word acceptance. The ring position is shared by all channels: it steps down
  // (wrapping to L-1) on channel 0 and is pulled back below L on every word, so a
  // window that was shrunk since the last word still lands on a valid row.
  // ---------------------------------------------------------------------------
  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    pos_w = WW'(pos_r);
    if (in_ch.channel == '0) begin
      pos_step = (pos_w == '0) ? eff.win - WW'(1) : pos_w - WW'(1);
    end else begin
      pos_step = pos_w;
    end
    pos_clamp = (pos_step >= eff.win) ? eff.win - WW'(1) : pos_step;
    pos_nxt   = PW'(pos_clamp);
  end

  assign in_range = 32'(in_ch.channel) < 32'(CHANNELS);

  // Inversion gives full scale minus the sample, floored at zero.
  assign s_diff = (SW + 1)'(FULL_SCALE) - (SW + 1)'(in_ch.sample);
  assign s_in   = !invert ? SW'(in_ch.sample) : (s_diff[SW] ? '0 : s_diff[SW-1:0]);

  // Seeding uses the raw sample, not the corrected one.
  assign raw_sh_in = {in_ch.sample, {bsr_pkg::SCALE_SH{1'b0}}};
  assign raw_sh    = {raw_r, {bsr_pkg::SCALE_SH{1'b0}}};
  assign t         = {s_r, {bsr_pkg::SCALE_SH{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= PW'(1);
    end else if (in_acc) begin
      pos_r <= pos_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  assign seed_last = WW'(seed_cnt_r) == eff.win - WW'(1);
  assign out_load  = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsr_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          priority if (!in_range) begin
            state_nxt = bsr_pkg::S_FINISH;
          end else if (in_ch.first_record) begin
            state_nxt = bsr_pkg::S_SEED;
          end else begin
            state_nxt = bsr_pkg::S_READ;
          end
        end
      end
      bsr_pkg::S_SEED: begin
        if (seed_last) begin
          state_nxt = bsr_pkg::S_SUM;
        end
      end
      bsr_pkg::S_READ:   state_nxt = bsr_pkg::S_SUM;
      bsr_pkg::S_SUM:    state_nxt = bsr_pkg::S_DIV;
      bsr_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = bsr_pkg::S_SAT;
        end
      end
      bsr_pkg::S_SAT:    state_nxt = bsr_pkg::S_RES;
      bsr_pkg::S_RES:    state_nxt = bsr_pkg::S_MUL;
      bsr_pkg::S_MUL:    state_nxt = bsr_pkg::S_FINISH;
      bsr_pkg::S_FINISH: begin
        if (out_load) begin
          state_nxt = bsr_pkg::S_IDLE;
        end
      end
      default:           state_nxt = bsr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready     = 1'b0;
    mem_ctl         = '0;
    mem_row         = pos_r;
    div_start       = 1'b0;
    do_sum          = 1'b0;
    do_sat          = 1'b0;
    do_res          = 1'b0;
    do_mul          = 1'b0;
    unique case (state_r)
      bsr_pkg::S_IDLE:   in_ch.ready = 1'b1;
      bsr_pkg::S_SEED: begin
        mem_ctl.ring_we = 1'b1;
        mem_row         = seed_cnt_r;
      end
      bsr_pkg::S_READ:   mem_ctl.rd = 1'b1;
      bsr_pkg::S_SUM: begin
        do_sum    = 1'b1;
        div_start = 1'b1;
      end
      bsr_pkg::S_SAT:    do_sat = 1'b1;
      bsr_pkg::S_RES: begin
        do_res          = 1'b1;
        mem_ctl.acc_we  = 1'b1;
        mem_ctl.ring_we = 1'b1;
      end
      bsr_pkg::S_MUL:    do_mul = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Channel state and divider.
  // ---------------------------------------------------------------------------
  assign ch_idx = CIW'(ch_r);

  bsr_chan_mem #(
    .CHANNELS (CHANNELS),
    .ROWS     (LMAX)
  ) u_mem (
    .clk        (clk),
    .ctl        (mem_ctl),
    .ch         (ch_idx),
    .row        (mem_row),
    .acc_wdata  (acc_upd),
    .ring_wdata (first_r && state_r == bsr_pkg::S_SEED ? raw_sh : avg_r),
    .acc_rdata  (mem_acc_rdata),
    .ring_rdata (mem_ring_rdata)
  );

  // A seeded word skips the memory read: its accumulator is raw*256*L and its
  // ring entry raw*256, both already in hand.
  assign acc_old  = first_r ? seed_acc_r : mem_acc_rdata;
  assign ring_old = first_r ? raw_sh : mem_ring_rdata;
  assign acc_sum  = acc_old - AW'(ring_old) + AW'(t);

  bsr_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_sum[DW-1:0]),
    .divisor  (eff.win),
    .done     (div_done),
    .quotient (quotient)
  );

  // A negative accumulator gives an average of zero or below, which saturates
  // to zero; a quotient above the ring width saturates to its top.
  always_comb begin
    if (acc_r[AW-1]) begin
      avg = '0;
    end else if (quotient[DW-1:RW] != '0) begin
      avg = bsr_pkg::RING_MAX;
    end else begin
      avg = quotient[RW-1:0];
    end
  end

  // The accumulator drops the new sample and keeps the new average instead.
  assign acc_upd = acc_r - AW'(t) + AW'(avg_r);

  // Division by 256 truncates toward zero, so negative values are biased first.
  assign diff     = $signed({2'b00, t}) - $signed({6'b0, avg_r});
  assign diff_adj = diff[RW+5] ? diff + (RW + 6)'(255) : diff;

  // ---------------------------------------------------------------------------
  // Output stage: full scale first, then the 12-bit field limit.
  // ---------------------------------------------------------------------------
  assign v = $signed({prod_r[bsr_pkg::PROD_W-1], prod_r}) + $signed(VW'(HALF));

  always_comb begin
    if (v[VW-1]) begin
      v_fs = '0;
    end else if (v > $signed(VW'(FULL_SCALE))) begin
      v_fs = SW'(FULL_SCALE);
    end else begin
      v_fs = v[SW-1:0];
    end
    filt = (v_fs > SW'(bsr_pkg::OUT_MAX)) ? bsr_pkg::OUT_MAX : v_fs[bsr_pkg::OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_cnt_r <= '0;
    end else if (in_acc) begin
      seed_cnt_r <= '0;
    end else if (state_r == bsr_pkg::S_SEED) begin
      seed_cnt_r <= seed_cnt_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r       <= in_ch.channel;
      raw_r      <= in_ch.sample;
      first_r    <= in_ch.first_record;
      s_r        <= s_in;
      rc_r       <= (s_in > SW'(bsr_pkg::OUT_MAX)) ? bsr_pkg::OUT_MAX
                                                   : s_in[bsr_pkg::OUT_W-1:0];
      seed_acc_r <= AW'(AW'(raw_sh_in) * AW'(eff.win));
      // A channel without state reports half scale only.
      prod_r     <= '0;
    end
    if (do_sum) begin
      acc_r <= acc_sum;
    end
    if (do_sat) begin
      avg_r <= avg;
    end
    if (do_res) begin
      res_r <= diff_adj[RW+5:bsr_pkg::SCALE_SH];
    end
    if (do_mul) begin
      prod_r <= res_r * $signed({1'b0, eff.gain});
    end
  end

  // The result register frees the core to take the next word while a finished
  // word still waits on the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == bsr_pkg::S_FINISH && out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bsr_pkg::S_FINISH && out_load) begin
      filt_out_r <= filt;
      rc_out_r   <= rc_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.filtered      = filt_out_r;
  assign out_ch.raw_corrected = rc_out_r;

endmodule

>>> dv/sensor_baseline_removal_filter_tb.sv
// Self-checking testbench for sensor_baseline_removal_filter: drives sample words, predicts
// every result word with a behavioral model of the per-channel baseline filter and compares.
// Depends on bsr_pkg and the bsr_in_if, bsr_out_if and bsr_cfg_if interfaces of the block.
`timescale 1ns / 1ps

module sensor_baseline_removal_filter_tb;

  localparam int CH_W       = bsr_pkg::CH_W;
  localparam int SAMPLE_W   = bsr_pkg::SAMPLE_W;
  localparam int OUT_W      = bsr_pkg::OUT_W;
  localparam int WIN_W      = bsr_pkg::WIN_W;
  localparam int GAIN_W     = bsr_pkg::GAIN_W;
  localparam int MASK_W     = bsr_pkg::MASK_W;
  localparam int ACC_W      = bsr_pkg::ACC_W;
  localparam int RING_W     = bsr_pkg::RING_W;
  localparam int CFG_DATA_W = bsr_pkg::CFG_DATA_W;

  localparam int FULL_SCALE = bsr_pkg::FULL_SCALE_DEF;
  localparam int HALF_SCALE = FULL_SCALE / 2;
  localparam int NUM_CHANNELS = bsr_pkg::CHANNELS_DEF;
  localparam int RING_DEPTH = bsr_pkg::MAX_WINDOW_DEF;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
    logic                first_record;
  } sample_word_t;

  typedef struct {
    logic [OUT_W-1:0] filtered;
    logic [OUT_W-1:0] raw_corrected;
  } result_word_t;

  logic clk;
  logic rst_n;

  bsr_in_if  in_if ();
  bsr_out_if out_if ();
  bsr_cfg_if cfg_if ();

  sensor_baseline_removal_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Words waiting to be offered, and result words predicted but not yet seen.
  sample_word_t pending_words[$];
  result_word_t expected_words[$];

  int queued_words   = 0;
  int accepted_words = 0;
  int checked_words  = 0;
  int mismatches     = 0;

  // Idling percentages, changed between phases only.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long receiver hold-off, started once by the stimulus and timed by its own process.
  logic hold_go     = 1'b0;
  logic result_hold = 1'b0;

  // Shadow copy of the filter: registers, per-channel accumulators, baseline rings and the
  // shared ring position. Values mirror the reset state of the block.
  logic [WIN_W-1:0]        shadow_window = bsr_pkg::WIN_RST;
  logic [GAIN_W-1:0]       shadow_gain   = bsr_pkg::GAIN_RST;
  logic [MASK_W-1:0]       shadow_inv_lo = '0;
  logic [MASK_W-1:0]       shadow_inv_hi = '0;
  logic signed [ACC_W-1:0] chan_acc [NUM_CHANNELS];
  logic [RING_W-1:0]       chan_ring [RING_DEPTH][NUM_CHANNELS];
  logic [3:0]              ring_pos = 4'd1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Computes the result word of one accepted sample word and updates the shadow state.
  // The arithmetic runs in 64-bit signed so that truncating division and the 25-bit
  // accumulator wrap can be written plainly.
  function automatic result_word_t filter_word(input sample_word_t w);
    result_word_t r;
    int ch;
    int win;
    int pos;
    logic inv;
    longint g;
    longint s;
    longint t;
    longint acc_now;
    longint avg;
    longint res;
    logic signed [ACC_W-1:0] acc_wrapped;
    ch = w.channel;
    win = shadow_window;
    if (win < 1) win = 1;
    if (win > RING_DEPTH) win = RING_DEPTH;
    g = shadow_gain;
    if (g == 0) g = 1;

    // Channel 0 opens a new record: the shared position steps down and wraps to L-1.
    if (ch == 0) begin
      if (ring_pos == 0) ring_pos = 4'(win - 1);
      else ring_pos = ring_pos - 4'd1;
    end
    // A window that shrank since the last step leaves the position out of range.
    if (ring_pos >= win) ring_pos = 4'(win - 1);
    pos = ring_pos;

    inv = (ch < 64) ? shadow_inv_lo[ch] : shadow_inv_hi[ch - 64];
    s = w.sample;
    if (inv) begin
      s = FULL_SCALE - s;
      if (s < 0) s = 0;
    end

    // Seeding takes the raw reading, not the inverted one.
    if (w.first_record) begin
      chan_acc[ch] = ACC_W'(longint'(w.sample) * 256 * win);
      for (int j = 0; j < win; j++) chan_ring[j][ch] = RING_W'(longint'(w.sample) * 256);
    end

    t = s * 256;
    acc_now = longint'(chan_acc[ch]) - longint'(chan_ring[pos][ch]) + t;
    acc_wrapped = acc_now[ACC_W-1:0];
    acc_now = acc_wrapped;
    avg = acc_now / win;
    if (avg < 0) avg = 0;
    if (avg > longint'(bsr_pkg::RING_MAX)) avg = longint'(bsr_pkg::RING_MAX);
    chan_ring[pos][ch] = avg[RING_W-1:0];
    chan_acc[ch] = ACC_W'(acc_now - t + avg);

    res = (t - avg) / 256;
    res = res * g + HALF_SCALE;
    if (res > FULL_SCALE) res = FULL_SCALE;
    if (res < 0) res = 0;
    if (res > longint'(bsr_pkg::OUT_MAX)) res = longint'(bsr_pkg::OUT_MAX);
    r.filtered = res[OUT_W-1:0];
    r.raw_corrected = (s > longint'(bsr_pkg::OUT_MAX)) ? bsr_pkg::OUT_MAX : s[OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    if (mismatches < MAX_PRINTED)
      $display("[%0t] MISMATCH %s: expected %0d, got %0d (result word %0d)",
               $realtime, what, want, got, checked_words);
    mismatches++;
  endtask

  // Driver: offers pending words, and on each accepted word runs the predictor.
  always @(posedge clk) begin : sample_driver
    sample_word_t taken;
    sample_word_t next_word;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        taken.channel = in_if.channel;
        taken.sample = in_if.sample;
        taken.first_record = in_if.first_record;
        expected_words.push_back(filter_word(taken));
        accepted_words <= accepted_words + 1;
      end
      // A word on the bus stays there until it is taken.
      if (!in_if.valid || in_if.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = pending_words.pop_front();
          in_if.valid <= 1'b1;
          in_if.channel <= next_word.channel;
          in_if.sample <= next_word.sample;
          in_if.first_record <= next_word.first_record;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result word against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    result_word_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result word, filtered", -1, out_if.filtered);
        end else begin
          want = expected_words.pop_front();
          if (out_if.filtered !== want.filtered)
            report_mismatch("filtered", want.filtered, out_if.filtered);
          if (out_if.raw_corrected !== want.raw_corrected)
            report_mismatch("raw_corrected", want.raw_corrected, out_if.raw_corrected);
        end
        checked_words <= checked_words + 1;
      end
      out_if.ready <= !result_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The one long hold-off of the result channel. The block fills up behind it and has to
  // stall its input while the driver keeps offering words.
  initial begin : long_result_hold
    wait (hold_go);
    @(posedge clk);
    result_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    result_hold <= 1'b0;
  end

  initial begin : run_limit
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("[%0t] timeout: %0d words queued, %0d accepted, %0d results checked",
             $realtime, queued_words, accepted_words, checked_words);
    $display("sensor_baseline_removal_filter test failed");
    $finish;
  end

  task automatic queue_word(input int ch, input int smp, input bit seed);
    sample_word_t w;
    w.channel = ch[CH_W-1:0];
    w.sample = smp[SAMPLE_W-1:0];
    w.first_record = seed;
    pending_words.push_back(w);
    queued_words++;
  endtask

  // Readings lean on the two rails now and then so that saturation keeps being hit.
  function automatic int pick_sample();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return FULL_SCALE;
    return $urandom_range(FULL_SCALE);
  endfunction

  // Waits at a clock edge until every queued word went in and every result came back.
  task automatic wait_drained();
    @(posedge clk);
    while (accepted_words != queued_words || checked_words != accepted_words)
      @(posedge clk);
  endtask

  // Register writes go out only while the block is idle; the shadow copy follows on the
  // handshake. valid drops for one edge before the next write raises it again.
  task automatic write_register(input bsr_pkg::bsr_cfg_idx_t idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      bsr_pkg::CFG_WINDOW: shadow_window = value[WIN_W-1:0];
      bsr_pkg::CFG_GAIN:   shadow_gain = value[GAIN_W-1:0];
      bsr_pkg::CFG_INV_LO: shadow_inv_lo = value;
      bsr_pkg::CFG_INV_HI: shadow_inv_hi = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
      default: begin send_idle_pct = 31; recv_stall_pct = 31; end
    endcase
  endtask

  // Random traffic: mostly records from channel 0 up, of 1 to 8 channels or now and then 64 to N,
  // some of which reseed, and a share of stray words with random channel and seed flag. The last
  // record is cut short so that exactly n_words go out.
  task automatic queue_random_traffic(input int n_words);
    int count;
    int rec_len;
    bit seed;
    count = 0;
    while (count < n_words) begin
      if ($urandom_range(99) < 85) begin
        rec_len = ($urandom_range(19) == 0) ? $urandom_range(64, NUM_CHANNELS)
                                            : $urandom_range(1, 8);
        if (rec_len > n_words - count) rec_len = n_words - count;
        seed = ($urandom_range(9) == 0);
        for (int c = 0; c < rec_len; c++) queue_word(c, pick_sample(), seed);
        count += rec_len;
      end else begin
        queue_word($urandom_range(NUM_CHANNELS - 1), pick_sample(), $urandom_range(1));
        count++;
      end
    end
  endtask

  initial begin : stimulus
    int win_set[8];
    int gain_set[8];
    logic [MASK_W-1:0] lo_set[8];
    logic [MASK_W-1:0] hi_set[8];
    // Every input of the block is known from time zero.
    in_if.valid = 1'b0;
    in_if.channel = '0;
    in_if.sample = '0;
    in_if.first_record = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = bsr_pkg::CFG_WINDOW;
    cfg_if.data = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Setup record: every channel is seeded with the widest window, so every accumulator
    // and every ring entry holds a value before anything reads it.
    set_idling(0);
    write_register(bsr_pkg::CFG_WINDOW, 64'd16);
    queue_word(0, 0, 1'b1);
    for (int c = 1; c < NUM_CHANNELS - 1; c++) queue_word(c, $urandom_range(FULL_SCALE), 1'b1);
    queue_word(NUM_CHANNELS - 1, FULL_SCALE, 1'b1);
    wait_drained();

    // Directed: the largest gain with alternating inversion, so both rails of the output
    // saturate and inverted and plain channels sit side by side in both mask halves.
    set_idling(1);
    write_register(bsr_pkg::CFG_GAIN, 64'd255);
    write_register(bsr_pkg::CFG_INV_LO, 64'h5555_5555_5555_5555);
    write_register(bsr_pkg::CFG_INV_HI, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_word(0, FULL_SCALE, 1'b0);
    queue_word(1, FULL_SCALE, 1'b0);
    queue_word(2, 0, 1'b0);
    queue_word(3, 0, 1'b0);
    queue_word(64, FULL_SCALE, 1'b0);
    queue_word(65, 0, 1'b0);
    queue_word(126, 2048, 1'b0);
    // Seeding an inverted channel uses the raw reading.
    queue_word(127, FULL_SCALE, 1'b1);
    queue_word(0, 0, 1'b1);
    wait_drained();

    // A window of zero and a gain of zero both act as one.
    set_idling(2);
    write_register(bsr_pkg::CFG_WINDOW, 64'd0);
    write_register(bsr_pkg::CFG_GAIN, 64'd0);
    queue_word(0, 2048, 1'b1);
    queue_word(0, 0, 1'b0);
    queue_word(0, FULL_SCALE, 1'b0);
    queue_word(5, 100, 1'b0);
    wait_drained();

    // The largest window value acts as the ring depth; all channels inverted.
    set_idling(3);
    write_register(bsr_pkg::CFG_WINDOW, 64'd31);
    write_register(bsr_pkg::CFG_GAIN, 64'd1);
    write_register(bsr_pkg::CFG_INV_LO, '1);
    write_register(bsr_pkg::CFG_INV_HI, '1);
    queue_word(0, FULL_SCALE, 1'b0);
    queue_word(1, 0, 1'b0);
    queue_word(127, 1, 1'b0);
    queue_word(100, 4094, 1'b1);
    wait_drained();

    // Random phases, each with its own setting. Shrinking windows between phases leave the
    // ring position beyond the window, which the block must clamp.
    win_set  = '{1, 5, 16, 0, 31, 3, 12, $urandom_range(1, 16)};
    gain_set = '{1, 255, 10, 0, 37, $urandom_range(1, 255), 200, $urandom_range(1, 255)};
    lo_set   = '{'0, '1, {$urandom, $urandom}, {$urandom, $urandom}, '0,
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
    hi_set   = '{'0, '0, {$urandom, $urandom}, {$urandom, $urandom}, '1,
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
    for (int p = 0; p < 8; p++) begin
      set_idling(p % 4);
      write_register(bsr_pkg::CFG_WINDOW, 64'(win_set[p]));
      write_register(bsr_pkg::CFG_GAIN, 64'(gain_set[p]));
      write_register(bsr_pkg::CFG_INV_LO, lo_set[p]);
      write_register(bsr_pkg::CFG_INV_HI, hi_set[p]);
      if (p == 2) begin
        // Result channel held off while words keep coming.
        hold_go = 1'b1;
        queue_random_traffic(100);
      end else if (p == 3) begin
        // The sender stops mid-phase until the block has emptied.
        queue_random_traffic(50);
        wait_drained();
        queue_random_traffic(50);
      end else begin
        queue_random_traffic(100);
      end
      wait_drained();
    end

    // Anything still in flight or arriving late shows up as a mismatch.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch("result words never delivered", 0, expected_words.size());
    if (mismatches == 0) begin
      $display("sensor_baseline_removal_filter test passed");
    end else begin
      $display("sensor_baseline_removal_filter test failed");
    end
    $finish;
  end

endmodule
